/* rtl/core/owm_pkg.sv */
// Shared types, codes and reset constants for the one-wire bus master.
// No dependencies; every other file in rtl/core refers to this package.
`default_nettype none

package owm_pkg;

   localparam int unsigned TICK_W  = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned BIT_W   = 3;
   localparam int unsigned CSR_A_W = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_A_W-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_SHORT_PULSE   = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_LONG_SLOT     = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_READ_PULSE    = 3'd4;

   // Reset values of the timing registers.
   localparam logic [TICK_W-1:0] RESET_LOW_DEFAULT     = 16'd500;
   localparam logic [TICK_W-1:0] PRESENCE_WAIT_DEFAULT = 16'd60;
   localparam logic [TICK_W-1:0] SHORT_PULSE_DEFAULT   = 16'd1;
   localparam logic [TICK_W-1:0] LONG_SLOT_DEFAULT     = 16'd60;
   localparam logic [TICK_W-1:0] READ_PULSE_DEFAULT    = 16'd2;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_RESET = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_READ  = 2'd3
   } req_kind_type;

   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_RST_LOW  = 8'b0000_0010,
      PH_RST_WAIT = 8'b0000_0100,
      PH_RST_REC  = 8'b0000_1000,
      PH_WR_LOW   = 8'b0001_0000,
      PH_WR_REL   = 8'b0010_0000,
      PH_RD_LOW   = 8'b0100_0000,
      PH_RD_REC   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] reset_low;
      logic [TICK_W-1:0] presence_wait;
      logic [TICK_W-1:0] short_pulse;
      logic [TICK_W-1:0] long_slot;
      logic [TICK_W-1:0] read_pulse;
   } cfg_type;

   typedef struct packed {
      phase_type         phase;
      logic [TICK_W-1:0] tick_count;
      logic [BIT_W-1:0]  bit_index;
      logic [BYTE_W-1:0] shift_data;
      logic              presence_flag;
      logic [BYTE_W-1:0] read_result;
   } state_type;

   typedef struct packed {
      logic              drive_low;
      logic              busy_res;
      logic              done_res;
      logic              presence;
      logic [BYTE_W-1:0] read_byte;
      logic              cmd_rejected;
   } rsp_type;

   // A duration of zero behaves as one tick.
   function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
      at_least_one = (v == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : v;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/owm_csr.sv */
// Timing configuration registers of the one-wire bus master.
// Depends on owm_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module owm_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_en,
   input  wire logic [owm_pkg::CSR_A_W-1:0]  csr_index,
   input  wire logic [owm_pkg::TICK_W-1:0]   csr_data,
   output owm_pkg::cfg_type                  cfg
);

   owm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            owm_pkg::CSR_RESET_LOW:     cfg_in.reset_low     = csr_data;
            owm_pkg::CSR_PRESENCE_WAIT: cfg_in.presence_wait = csr_data;
            owm_pkg::CSR_SHORT_PULSE:   cfg_in.short_pulse   = csr_data;
            owm_pkg::CSR_LONG_SLOT:     cfg_in.long_slot     = csr_data;
            owm_pkg::CSR_READ_PULSE:    cfg_in.read_pulse    = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low     <= owm_pkg::RESET_LOW_DEFAULT;
         cfg_ff.presence_wait <= owm_pkg::PRESENCE_WAIT_DEFAULT;
         cfg_ff.short_pulse   <= owm_pkg::SHORT_PULSE_DEFAULT;
         cfg_ff.long_slot     <= owm_pkg::LONG_SLOT_DEFAULT;
         cfg_ff.read_pulse    <= owm_pkg::READ_PULSE_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/core/owm_step.sv */
// One tick of the bus sequencer: next state and the result word.
// Purely combinational; depends on owm_pkg for types and codes.
`default_nettype none

module owm_step (
   input  wire owm_pkg::state_type            state_cur,
   input  wire owm_pkg::cfg_type              cfg,
   input  wire logic [1:0]                    req_type,
   input  wire logic [owm_pkg::BYTE_W-1:0]    cmd_byte,
   input  wire logic                          line_level,
   output owm_pkg::state_type                 state_next,
   output owm_pkg::rsp_type                   rsp
);

   owm_pkg::state_type     st;
   owm_pkg::req_kind_type  kind;
   logic [owm_pkg::TICK_W-1:0] len;
   logic [owm_pkg::TICK_W-1:0] tick_inc;
   logic                   cur_bit;
   logic                   busy;
   logic                   drive;
   logic                   done;
   logic                   rejected;

   always_comb begin
      st       = state_cur;
      kind     = owm_pkg::req_kind_type'(req_type);
      rejected = 1'b0;
      busy     = 1'b0;
      drive    = 1'b0;
      done     = 1'b0;
      tick_inc = '0;

      // A command taken in idle already counts as the first tick of its sequence.
      if (st.phase == owm_pkg::PH_IDLE) begin
         if (kind != owm_pkg::REQ_TICK) begin
            st.tick_count = '0;
            st.bit_index  = '0;
            case (kind)
               owm_pkg::REQ_RESET: begin
                  st.phase = owm_pkg::PH_RST_LOW;
               end
               owm_pkg::REQ_WRITE: begin
                  st.phase      = owm_pkg::PH_WR_LOW;
                  st.shift_data = cmd_byte;
               end
               default: begin
                  st.phase      = owm_pkg::PH_RD_LOW;
                  st.shift_data = '0;
               end
            endcase
         end
      end else if (kind != owm_pkg::REQ_TICK) begin
         rejected = 1'b1;
      end

      cur_bit = st.shift_data[st.bit_index];

      case (st.phase)
         owm_pkg::PH_RST_LOW:  len = owm_pkg::at_least_one(cfg.reset_low);
         owm_pkg::PH_RST_WAIT: len = owm_pkg::at_least_one(cfg.presence_wait);
         owm_pkg::PH_RST_REC:  len = owm_pkg::at_least_one(cfg.reset_low);
         owm_pkg::PH_WR_LOW:   len = cur_bit ? owm_pkg::at_least_one(cfg.short_pulse)
                                             : owm_pkg::at_least_one(cfg.long_slot);
         owm_pkg::PH_WR_REL:   len = cur_bit ? owm_pkg::at_least_one(cfg.long_slot)
                                             : owm_pkg::TICK_W'(1);
         owm_pkg::PH_RD_LOW:   len = owm_pkg::at_least_one(cfg.read_pulse);
         owm_pkg::PH_RD_REC:   len = owm_pkg::at_least_one(cfg.long_slot);
         default:              len = owm_pkg::TICK_W'(1);
      endcase

      if (st.phase != owm_pkg::PH_IDLE) begin
         busy  = 1'b1;
         drive = (st.phase == owm_pkg::PH_RST_LOW) || (st.phase == owm_pkg::PH_WR_LOW) ||
                 (st.phase == owm_pkg::PH_RD_LOW);

         // The bus is sampled on the first tick of the recovery phases.
         if (st.tick_count == '0) begin
            if (st.phase == owm_pkg::PH_RST_REC) begin
               st.presence_flag = ~line_level;
            end else if (st.phase == owm_pkg::PH_RD_REC) begin
               st.shift_data[st.bit_index] = st.shift_data[st.bit_index] | line_level;
            end
         end

         tick_inc = st.tick_count + owm_pkg::TICK_W'(1);
         if (tick_inc >= len) begin
            st.tick_count = '0;
            case (st.phase)
               owm_pkg::PH_RST_LOW:  st.phase = owm_pkg::PH_RST_WAIT;
               owm_pkg::PH_RST_WAIT: st.phase = owm_pkg::PH_RST_REC;
               owm_pkg::PH_RST_REC: begin
                  st.phase = owm_pkg::PH_IDLE;
                  done     = 1'b1;
               end
               owm_pkg::PH_WR_LOW:   st.phase = owm_pkg::PH_WR_REL;
               owm_pkg::PH_RD_LOW:   st.phase = owm_pkg::PH_RD_REC;
               owm_pkg::PH_WR_REL, owm_pkg::PH_RD_REC: begin
                  if (st.bit_index == '1) begin
                     if (st.phase == owm_pkg::PH_RD_REC) begin
                        st.read_result = st.shift_data;
                     end
                     st.phase     = owm_pkg::PH_IDLE;
                     st.bit_index = '0;
                     done         = 1'b1;
                  end else begin
                     st.bit_index = st.bit_index + owm_pkg::BIT_W'(1);
                     st.phase     = (st.phase == owm_pkg::PH_WR_REL) ? owm_pkg::PH_WR_LOW
                                                                     : owm_pkg::PH_RD_LOW;
                  end
               end
               default:              st.phase = owm_pkg::PH_IDLE;
            endcase
         end else begin
            st.tick_count = tick_inc;
         end
      end

      state_next       = st;
      rsp.drive_low    = drive;
      rsp.busy_res     = busy;
      rsp.done_res     = done;
      rsp.presence     = st.presence_flag;
      rsp.read_byte    = st.read_result;
      rsp.cmd_rejected = rejected;
   end

endmodule

`default_nettype wire

/* rtl/core/one_wire_bus_master_top.sv */
// One-wire bus master: input register, tick sequencer and output register.
// Depends on owm_pkg, owm_csr and owm_step.
//
// Each request word is one timing tick of the bus. req_type starts a reset with
// presence detection, a byte write or a byte read (LSB first); a plain tick just
// advances the running sequence. Every request word yields exactly one response
// word on the rsp_ channel with the line drive, busy/done flags, the presence
// flag, the last byte read, and a flag for a command that arrived while busy.
// A word is taken at a clock edge where valid is high and stall is low.
// A word passes first into the input register, then through the sequencer into the
// response register. One word is taken per clock while the receiver does not stall; the
// sequencer state advances in the same cycle the word moves to the response
// register, so only the one 16-bit tick add and compare sits in that loop.
// When the receiver stalls, the response register holds and the input register
// fills; req_stall rises only once both are occupied.
// Synchronous reset empties both registers, returns the sequencer to idle with
// cleared presence and read byte, and loads the default tick counts. Timing
// registers are written through the csr_ port and take effect at once.
`default_nettype none

module one_wire_bus_master_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Request channel.
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic [1:0]                   req_type,
   input  wire logic [owm_pkg::BYTE_W-1:0]   req_cmd_byte,
   input  wire logic                         req_line_level,
   // Response channel.
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic                         rsp_drive_low,
   output      logic                         rsp_busy_res,
   output      logic                         rsp_done_res,
   output      logic                         rsp_presence,
   output      logic [owm_pkg::BYTE_W-1:0]   rsp_read_byte,
   output      logic                         rsp_cmd_rejected,
   // Configuration port.
   input  wire logic                         csr_write_en,
   input  wire logic [owm_pkg::CSR_A_W-1:0]  csr_index,
   input  wire logic [owm_pkg::TICK_W-1:0]   csr_data
);

   owm_pkg::cfg_type   cfg;
   owm_pkg::state_type state_ff, state_in;
   owm_pkg::rsp_type   step_rsp;
   owm_pkg::rsp_type   rsp_ff;

   logic                       in_valid_ff, in_valid_in;
   logic [1:0]                 in_type_ff;
   logic [owm_pkg::BYTE_W-1:0] in_byte_ff;
   logic                       in_line_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       req_take;
   logic                       advance;

   owm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   owm_step u_step (
      .state_cur  (state_ff),
      .cfg        (cfg),
      .req_type   (in_type_ff),
      .cmd_byte   (in_byte_ff),
      .line_level (in_line_ff),
      .state_next (state_in),
      .rsp        (step_rsp)
   );

   // A held word moves forward when the response register is empty or being taken.
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         state_ff.phase         <= owm_pkg::PH_IDLE;
         state_ff.tick_count    <= '0;
         state_ff.bit_index     <= '0;
         state_ff.shift_data    <= '0;
         state_ff.presence_flag <= 1'b0;
         state_ff.read_result   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff <= req_type;
         in_byte_ff <= req_cmd_byte;
         in_line_ff <= req_line_level;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_low    = rsp_ff.drive_low;
   assign rsp_busy_res     = rsp_ff.busy_res;
   assign rsp_done_res     = rsp_ff.done_res;
   assign rsp_presence     = rsp_ff.presence;
   assign rsp_read_byte    = rsp_ff.read_byte;
   assign rsp_cmd_rejected = rsp_ff.cmd_rejected;

endmodule

`default_nettype wire
